// ----- hdl/sawarq_pkg.sv -----
// Shared types and constants for the stop-and-wait ARQ controller.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package sawarq_pkg;

   // Field widths fixed by the link interface
   localparam int REQ_TYPE_W = 3;
   localparam int FIELD_W    = 8;
   localparam int ACTION_W   = 3;
   localparam int STATE_W    = 2;
   localparam int RETRY_W    = 8;
   localparam int TICKS_W    = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_ID       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RETX      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEQ_MODULUS   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 2'd3;

   localparam logic [FIELD_W-1:0] DEST_ID_RESET       = 8'd0;
   localparam logic [FIELD_W-1:0] MAX_RETX_RESET      = 8'd3;
   localparam logic [FIELD_W-1:0] SEQ_MODULUS_RESET   = 8'd4;
   localparam logic [TICKS_W-1:0] TIMEOUT_TICKS_RESET = 16'd1000;

   // Pending event bit positions
   localparam int EV_SDU   = 0;
   localparam int EV_DRX   = 1;
   localparam int EV_DTX   = 2;
   localparam int EV_ATX   = 3;
   localparam int EV_ARX   = 4;
   localparam int EV_TO    = 5;
   localparam int EV_COUNT = 6;

   // Per-transaction limits on the serve loop
   localparam int SERVE_LIMIT  = 8;
   localparam int RESULT_LIMIT = 4;
   localparam int GUARD_W      = $clog2(SERVE_LIMIT + 1);
   localparam int NRES_W       = $clog2(RESULT_LIMIT + 1);

   // Event queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [REQ_TYPE_W-1:0] {
      EVK_TICK = 3'd0,
      EVK_SDU  = 3'd1,
      EVK_DRX  = 3'd2,
      EVK_DTX  = 3'd3,
      EVK_ATX  = 3'd4,
      EVK_ARX  = 3'd5
   } ev_kind_type;

   typedef enum logic [STATE_W-1:0] {
      LINK_IDLE     = 2'd0,
      LINK_TX       = 2'd1,
      LINK_WAIT_ACK = 2'd2
   } main_state_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SEND_DATA   = 3'd0,
      ACT_RESEND_DATA = 3'd1,
      ACT_SEND_ACK    = 3'd2,
      ACT_ACK_OK      = 3'd3,
      ACT_GAVE_UP     = 3'd4,
      ACT_REJECTED    = 3'd5
   } action_type;

   typedef struct packed {
      logic [FIELD_W-1:0] dest_id;
      logic [FIELD_W-1:0] max_retx;
      logic [FIELD_W-1:0] seq_modulus;
      logic [TICKS_W-1:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      ev_kind_type        kind;
      logic [FIELD_W-1:0] rx_seq;
      logic [FIELD_W-1:0] rx_src;
   } queue_entry_type;

   typedef struct packed {
      action_type         action;
      logic [FIELD_W-1:0] seq;
      logic [FIELD_W-1:0] dest;
      main_state_type     state_now;
      logic               last;
   } result_type;

endpackage

// ----- hdl/sawarq_if.sv -----
// Valid/ready channel interfaces for event requests and link command responses.
// Depends on sawarq_pkg for field widths.
`timescale 1ns / 1ps

interface sawarq_req_if import sawarq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [FIELD_W-1:0]    rx_seq;
   logic [FIELD_W-1:0]    rx_src;

   modport source (output valid, output req_type, output rx_seq, output rx_src, input ready);
   modport sink   (input valid, input req_type, input rx_seq, input rx_src, output ready);
endinterface

interface sawarq_rsp_if import sawarq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [FIELD_W-1:0]  seq;
   logic [FIELD_W-1:0]  dest;
   logic [STATE_W-1:0]  state_now;
   logic                last;

   modport source (output valid, output action, output seq, output dest, output state_now,
                   output last, input ready);
   modport sink   (input valid, input action, input seq, input dest, input state_now,
                   input last, output ready);
endinterface

// ----- hdl/stop_and_wait_arq_controller_unit.sv -----
// Stop-and-wait ARQ controller, top level: configuration registers, front end
// event queue and back end state machine. Depends on sawarq_pkg, sawarq_if,
// sawarq_front and sawarq_back.
// An accepted transaction is queued, then popped and applied to the pending
// set; pending events are then served one per cycle while no result waits
// on a stalled response channel, each result going through a holding register
// to the output register. No new transaction is taken before the last is done;
// the 2-entry queue absorbs short bursts. Reset (synchronous, active high) clears
// the machine, the queue and the output, and loads the register defaults.
`timescale 1ns / 1ps

module stop_and_wait_arq_controller_unit
   import sawarq_pkg::*;
#(
   parameter int SEQ_BITS   = 8,
   parameter int TIMER_BITS = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   sawarq_req_if.sink             req_chan,
   sawarq_rsp_if.source           rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type         cfg_ff, cfg_in;
   logic            q_valid;
   logic            q_pop;
   queue_entry_type q_entry;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DEST_ID:       cfg_in.dest_id       = csr_write_data[FIELD_W-1:0];
            CSR_MAX_RETX:      cfg_in.max_retx      = csr_write_data[FIELD_W-1:0];
            CSR_SEQ_MODULUS:   cfg_in.seq_modulus   = csr_write_data[FIELD_W-1:0];
            CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_write_data[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{dest_id: DEST_ID_RESET, max_retx: MAX_RETX_RESET,
                     seq_modulus: SEQ_MODULUS_RESET, timeout_ticks: TIMEOUT_TICKS_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sawarq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_pop    (q_pop)
   );

   sawarq_back #(
      .SEQ_BITS   (SEQ_BITS),
      .TIMER_BITS (TIMER_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- hdl/sawarq_front.sv -----
// Front end: takes request transactions, classifies the event type and
// queues valid events for the back end. Depends on sawarq_pkg and sawarq_if.
`timescale 1ns / 1ps

module sawarq_front
   import sawarq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   sawarq_req_if.sink      req_chan,
   output logic            q_valid,
   output queue_entry_type q_entry,
   input  logic            q_pop
);

   queue_entry_type     entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                accept;
   logic                known;
   logic                push;
   ev_kind_type         kind;

   assign kind           = ev_kind_type'(req_chan.req_type);
   assign req_chan.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign accept         = req_chan.valid && req_chan.ready;
   assign q_valid        = (count_ff != '0);
   assign q_entry        = entries_ff[rd_ptr_ff];

   // Unused type codes are taken and dropped here
   always_comb begin
      unique case (kind) inside
         EVK_TICK, EVK_SDU, EVK_DRX, EVK_DTX, EVK_ATX, EVK_ARX: known = 1'b1;
         default: known = 1'b0;
      endcase
   end

   assign push = accept && known;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !q_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && q_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= '{kind: kind, rx_seq: req_chan.rx_seq,
                                    rx_src: req_chan.rx_src};
      end
   end

endmodule

// ----- hdl/sawarq_back.sv -----
// Back end: applies a queued event to the pending set and timer, then runs the ARQ
// machine one pending event per cycle unless stalled; uses sawarq_pkg, sawarq_if.
`timescale 1ns / 1ps

module sawarq_back
   import sawarq_pkg::*;
#(
   parameter int SEQ_BITS   = 8,
   parameter int TIMER_BITS = 16
)
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            q_valid,
   input  queue_entry_type q_entry,
   output logic            q_pop,
   sawarq_rsp_if.source    rsp_chan
);

   localparam int LIM_W = (TIMER_BITS > TICKS_W) ? TIMER_BITS : TICKS_W;
   localparam int CMP_W = FIELD_W + 1;

   typedef enum logic {
      B_IDLE,
      B_SERVE
   } back_state_type;

   back_state_type          bstate_ff, bstate_in;
   main_state_type          mstate_ff, mstate_in;
   logic [SEQ_BITS-1:0]     next_seq_ff, next_seq_in;
   logic [SEQ_BITS-1:0]     outst_ff, outst_in;
   logic [RETRY_W-1:0]      retry_ff, retry_in;
   logic [TIMER_BITS-1:0]   timer_cnt_ff, timer_cnt_in;
   logic                    timer_run_ff, timer_run_in;
   logic [EV_COUNT-1:0]     pend_ff, pend_in;
   logic [SEQ_BITS-1:0]     prx_seq_ff, prx_seq_in;
   logic [FIELD_W-1:0]      prx_src_ff, prx_src_in;
   logic [GUARD_W-1:0]      guard_ff, guard_in;
   logic [NRES_W-1:0]       nres_ff, nres_in;
   logic                    held_valid_ff, held_valid_in;
   result_type              held_ff, held_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_data_ff, rsp_data_in;

   // One serve step of the ARQ machine
   logic                    sv_handled;
   logic                    sv_emit;
   main_state_type          sv_mstate;
   logic [SEQ_BITS-1:0]     sv_next_seq;
   logic [SEQ_BITS-1:0]     sv_outst;
   logic [RETRY_W-1:0]      sv_retry;
   logic [TIMER_BITS-1:0]   sv_timer_cnt;
   logic                    sv_timer_run;
   logic [EV_COUNT-1:0]     sv_pend;
   action_type              sv_act;
   logic [FIELD_W-1:0]      sv_seq;
   logic [FIELD_W-1:0]      sv_dest;

   logic [SEQ_BITS:0]       seq_inc;
   logic                    seq_wrap;
   logic [SEQ_BITS-1:0]     seq_after;
   logic [TIMER_BITS-1:0]   cnt_inc;
   logic [LIM_W-1:0]        ticks_ext;
   logic [LIM_W-1:0]        cnt_max;
   logic [LIM_W-1:0]        limit;
   logic                    out_free;
   logic                    done;

   assign seq_inc   = {1'b0, next_seq_ff} + (SEQ_BITS + 1)'(1);
   assign seq_wrap  = seq_inc[SEQ_BITS] || (CMP_W'(seq_inc) >= CMP_W'(cfg.seq_modulus));
   assign seq_after = seq_wrap ? '0 : seq_inc[SEQ_BITS-1:0];

   assign cnt_inc   = timer_cnt_ff + TIMER_BITS'(1);
   assign ticks_ext = LIM_W'(cfg.timeout_ticks);
   assign cnt_max   = LIM_W'({TIMER_BITS{1'b1}});
   assign limit     = (ticks_ext > cnt_max) ? cnt_max : ticks_ext;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      sv_handled   = 1'b1;
      sv_emit      = 1'b0;
      sv_mstate    = mstate_ff;
      sv_next_seq  = next_seq_ff;
      sv_outst     = outst_ff;
      sv_retry     = retry_ff;
      sv_timer_cnt = timer_cnt_ff;
      sv_timer_run = timer_run_ff;
      sv_pend      = pend_ff;
      sv_act       = ACT_REJECTED;
      sv_seq       = '0;
      sv_dest      = '0;
      unique case (mstate_ff)
         LINK_IDLE: begin
            if (pend_ff[EV_DRX]) begin
               sv_pend[EV_DRX] = 1'b0;
               sv_mstate       = LINK_TX;
               sv_emit         = 1'b1;
               sv_act          = ACT_SEND_ACK;
               sv_seq          = FIELD_W'(prx_seq_ff);
               sv_dest         = prx_src_ff;
            end else if (pend_ff[EV_SDU]) begin
               sv_pend[EV_SDU] = 1'b0;
               sv_outst        = next_seq_ff;
               sv_next_seq     = seq_after;
               sv_retry        = '0;
               sv_mstate       = LINK_TX;
               sv_emit         = 1'b1;
               sv_act          = ACT_SEND_DATA;
               sv_seq          = FIELD_W'(next_seq_ff);
               sv_dest         = cfg.dest_id;
            end else if (pend_ff[EV_DTX] || pend_ff[EV_ATX] || pend_ff[EV_ARX]) begin
               if (pend_ff[EV_DTX]) begin
                  sv_pend[EV_DTX] = 1'b0;
               end else if (pend_ff[EV_ATX]) begin
                  sv_pend[EV_ATX] = 1'b0;
               end else begin
                  sv_pend[EV_ARX] = 1'b0;
               end
               sv_emit = 1'b1;
            end else begin
               sv_handled = 1'b0;
            end
         end
         LINK_TX: begin
            if (pend_ff[EV_DTX]) begin
               sv_pend[EV_DTX] = 1'b0;
               sv_timer_cnt    = '0;
               sv_timer_run    = 1'b1;
               sv_mstate       = LINK_WAIT_ACK;
            end else if (pend_ff[EV_ATX]) begin
               sv_pend[EV_ATX] = 1'b0;
               sv_mstate = (!timer_run_ff && !pend_ff[EV_TO]) ? LINK_IDLE : LINK_WAIT_ACK;
            end else if (pend_ff[EV_SDU]) begin
               sv_pend[EV_SDU] = 1'b0;
               sv_emit         = 1'b1;
            end else begin
               sv_handled = 1'b0;
            end
         end
         LINK_WAIT_ACK: begin
            if (pend_ff[EV_ARX]) begin
               sv_pend[EV_ARX] = 1'b0;
               sv_timer_run    = 1'b0;
               sv_mstate       = LINK_IDLE;
               sv_emit         = 1'b1;
               sv_act          = ACT_ACK_OK;
               sv_seq          = FIELD_W'(outst_ff);
               sv_dest         = cfg.dest_id;
            end else if (pend_ff[EV_TO]) begin
               sv_pend[EV_TO] = 1'b0;
               sv_emit        = 1'b1;
               sv_seq         = FIELD_W'(outst_ff);
               sv_dest        = cfg.dest_id;
               if (retry_ff < cfg.max_retx) begin
                  sv_retry  = retry_ff + RETRY_W'(1);
                  sv_mstate = LINK_TX;
                  sv_act    = ACT_RESEND_DATA;
               end else begin
                  sv_mstate = LINK_IDLE;
                  sv_act    = ACT_GAVE_UP;
               end
            end else if (pend_ff[EV_DRX]) begin
               sv_pend[EV_DRX] = 1'b0;
               sv_mstate       = LINK_TX;
               sv_emit         = 1'b1;
               sv_act          = ACT_SEND_ACK;
               sv_seq          = FIELD_W'(prx_seq_ff);
               sv_dest         = prx_src_ff;
            end else begin
               sv_handled = 1'b0;
            end
         end
         default: sv_handled = 1'b0;
      endcase
   end

   assign done = (guard_ff == GUARD_W'(SERVE_LIMIT)) || (nres_ff == NRES_W'(RESULT_LIMIT))
                 || !sv_handled;

   always_comb begin
      bstate_in     = bstate_ff;
      mstate_in     = mstate_ff;
      next_seq_in   = next_seq_ff;
      outst_in      = outst_ff;
      retry_in      = retry_ff;
      timer_cnt_in  = timer_cnt_ff;
      timer_run_in  = timer_run_ff;
      pend_in       = pend_ff;
      prx_seq_in    = prx_seq_ff;
      prx_src_in    = prx_src_ff;
      guard_in      = guard_ff;
      nres_in       = nres_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      unique case (bstate_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               guard_in  = '0;
               nres_in   = '0;
               bstate_in = B_SERVE;
               unique case (q_entry.kind)
                  EVK_TICK: begin
                     if (timer_run_ff) begin
                        timer_cnt_in = cnt_inc;
                        if (LIM_W'(cnt_inc) >= limit) begin
                           timer_run_in   = 1'b0;
                           pend_in[EV_TO] = 1'b1;
                        end
                     end
                  end
                  EVK_SDU: begin
                     if (mstate_ff == LINK_IDLE) begin
                        pend_in[EV_SDU] = 1'b1;
                     end
                  end
                  EVK_DRX: begin
                     pend_in[EV_DRX] = 1'b1;
                     prx_seq_in      = q_entry.rx_seq[SEQ_BITS-1:0];
                     prx_src_in      = q_entry.rx_src;
                  end
                  EVK_DTX: pend_in[EV_DTX] = 1'b1;
                  EVK_ATX: pend_in[EV_ATX] = 1'b1;
                  EVK_ARX: pend_in[EV_ARX] = 1'b1;
                  default: ;
               endcase
            end
         end
         B_SERVE: begin
            if (done) begin
               // the held result is the final one of this transaction
               if (!held_valid_ff) begin
                  bstate_in = B_IDLE;
               end else if (out_free) begin
                  rsp_valid_in     = 1'b1;
                  rsp_data_in      = held_ff;
                  rsp_data_in.last = 1'b1;
                  held_valid_in    = 1'b0;
                  bstate_in        = B_IDLE;
               end
            end else if (!(sv_emit && held_valid_ff && !out_free)) begin
               mstate_in    = sv_mstate;
               next_seq_in  = sv_next_seq;
               outst_in     = sv_outst;
               retry_in     = sv_retry;
               timer_cnt_in = sv_timer_cnt;
               timer_run_in = sv_timer_run;
               pend_in      = sv_pend;
               guard_in     = guard_ff + GUARD_W'(1);
               if (sv_emit) begin
                  if (held_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = held_ff;
                  end
                  held_valid_in = 1'b1;
                  held_in       = '{action: sv_act, seq: sv_seq, dest: sv_dest,
                                    state_now: sv_mstate, last: 1'b0};
                  nres_in       = nres_ff + NRES_W'(1);
               end
            end
         end
         default: bstate_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff     <= B_IDLE;
         mstate_ff     <= LINK_IDLE;
         next_seq_ff   <= '0;
         outst_ff      <= '0;
         retry_ff      <= '0;
         timer_cnt_ff  <= '0;
         timer_run_ff  <= 1'b0;
         pend_ff       <= '0;
         prx_seq_ff    <= '0;
         prx_src_ff    <= '0;
         guard_ff      <= '0;
         nres_ff       <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bstate_ff     <= bstate_in;
         mstate_ff     <= mstate_in;
         next_seq_ff   <= next_seq_in;
         outst_ff      <= outst_in;
         retry_ff      <= retry_in;
         timer_cnt_ff  <= timer_cnt_in;
         timer_run_ff  <= timer_run_in;
         pend_ff       <= pend_in;
         prx_seq_ff    <= prx_seq_in;
         prx_src_ff    <= prx_src_in;
         guard_ff      <= guard_in;
         nres_ff       <= nres_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.action    = rsp_data_ff.action;
   assign rsp_chan.seq       = rsp_data_ff.seq;
   assign rsp_chan.dest      = rsp_data_ff.dest;
   assign rsp_chan.state_now = rsp_data_ff.state_now;
   assign rsp_chan.last      = rsp_data_ff.last;

endmodule

// ----- dv/sawarq_link_checker.sv -----
// Scoreboard for the stop-and-wait ARQ controller: tracks CSR writes, predicts
// the link commands of every event transaction and compares them in order.
// Depends on sawarq_pkg and the channel interfaces in sawarq_if.
`timescale 1ns / 1ps

module sawarq_link_checker
   import sawarq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   sawarq_req_if                  req_mon,
   sawarq_rsp_if                  rsp_mon,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                     fail_count,
   output int                     expect_count,
   output int                     event_count,
   output int                     cmd_count
);

   // Shadow of the controller
   cfg_type              cfg;
   main_state_type       link_state;
   logic [FIELD_W-1:0]   next_seq_num;
   logic [FIELD_W-1:0]   out_seq;
   logic [RETRY_W-1:0]   retries;
   logic [TICKS_W-1:0]   tick_count;
   logic                 timer_on;
   logic [EV_COUNT-1:0]  pend;
   logic [FIELD_W-1:0]   pend_rx_seq;
   logic [FIELD_W-1:0]   pend_rx_src;

   result_type           expected_cmds[$];
   result_type           want;
   int                   errors;
   int                   events_seen;
   int                   cmds_seen;

   // Serves the highest-priority pending event of the current state.
   // Returns 0 when the state handles none of them.
   function automatic bit serve_one(output bit has_cmd, output result_type cmd);
      logic [FIELD_W:0] nx;
      has_cmd   = 1'b0;
      cmd       = '0;
      serve_one = 1'b1;
      case (link_state)
         LINK_IDLE: begin
            if (pend[EV_DRX]) begin
               pend[EV_DRX] = 1'b0;
               link_state   = LINK_TX;
               has_cmd      = 1'b1;
               cmd.action   = ACT_SEND_ACK;
               cmd.seq      = pend_rx_seq;
               cmd.dest     = pend_rx_src;
            end else if (pend[EV_SDU]) begin
               nx           = {1'b0, next_seq_num} + (FIELD_W + 1)'(1);
               pend[EV_SDU] = 1'b0;
               out_seq      = next_seq_num;
               next_seq_num = (nx >= {1'b0, cfg.seq_modulus}) ? '0 : nx[FIELD_W-1:0];
               retries      = '0;
               link_state   = LINK_TX;
               has_cmd      = 1'b1;
               cmd.action   = ACT_SEND_DATA;
               cmd.seq      = out_seq;
               cmd.dest     = cfg.dest_id;
            end else if (pend[EV_DTX] || pend[EV_ATX] || pend[EV_ARX]) begin
               if (pend[EV_DTX])      pend[EV_DTX] = 1'b0;
               else if (pend[EV_ATX]) pend[EV_ATX] = 1'b0;
               else                   pend[EV_ARX] = 1'b0;
               has_cmd    = 1'b1;
               cmd.action = ACT_REJECTED;
            end else begin
               serve_one = 1'b0;
            end
         end
         LINK_TX: begin
            if (pend[EV_DTX]) begin
               pend[EV_DTX] = 1'b0;
               tick_count   = '0;
               timer_on     = 1'b1;
               link_state   = LINK_WAIT_ACK;
            end else if (pend[EV_ATX]) begin
               pend[EV_ATX] = 1'b0;
               // a pending timeout still counts as an armed timer here
               link_state   = (!timer_on && !pend[EV_TO]) ? LINK_IDLE : LINK_WAIT_ACK;
            end else if (pend[EV_SDU]) begin
               pend[EV_SDU] = 1'b0;
               has_cmd      = 1'b1;
               cmd.action   = ACT_REJECTED;
            end else begin
               serve_one = 1'b0;
            end
         end
         LINK_WAIT_ACK: begin
            if (pend[EV_ARX]) begin
               pend[EV_ARX] = 1'b0;
               timer_on     = 1'b0;
               link_state   = LINK_IDLE;
               has_cmd      = 1'b1;
               cmd.action   = ACT_ACK_OK;
               cmd.seq      = out_seq;
               cmd.dest     = cfg.dest_id;
            end else if (pend[EV_TO]) begin
               pend[EV_TO] = 1'b0;
               has_cmd     = 1'b1;
               cmd.seq     = out_seq;
               cmd.dest    = cfg.dest_id;
               if (retries < cfg.max_retx) begin
                  retries    = retries + RETRY_W'(1);
                  link_state = LINK_TX;
                  cmd.action = ACT_RESEND_DATA;
               end else begin
                  link_state = LINK_IDLE;
                  cmd.action = ACT_GAVE_UP;
               end
            end else if (pend[EV_DRX]) begin
               pend[EV_DRX] = 1'b0;
               link_state   = LINK_TX;
               has_cmd      = 1'b1;
               cmd.action   = ACT_SEND_ACK;
               cmd.seq      = pend_rx_seq;
               cmd.dest     = pend_rx_src;
            end else begin
               serve_one = 1'b0;
            end
         end
         default: serve_one = 1'b0;
      endcase
      cmd.state_now = link_state;
   endfunction

   // Applies one event transaction and queues the link commands it causes.
   function automatic void predict_link_commands(logic [REQ_TYPE_W-1:0] kind,
                                                 logic [FIELD_W-1:0] rx_seq,
                                                 logic [FIELD_W-1:0] rx_src);
      result_type cmds[RESULT_LIMIT];
      result_type cmd;
      bit         has_cmd;
      bit         busy;
      int         n;
      int         guard;
      n     = 0;
      guard = 0;
      busy  = 1'b1;
      case (kind)
         EVK_TICK: begin
            if (timer_on) begin
               tick_count = tick_count + TICKS_W'(1);
               // a zero limit behaves like one tick
               if (tick_count >= cfg.timeout_ticks) begin
                  timer_on    = 1'b0;
                  pend[EV_TO] = 1'b1;
               end
            end
         end
         EVK_SDU: if (link_state == LINK_IDLE) pend[EV_SDU] = 1'b1;
         EVK_DRX: begin
            pend[EV_DRX] = 1'b1;
            pend_rx_seq  = rx_seq;
            pend_rx_src  = rx_src;
         end
         EVK_DTX: pend[EV_DTX] = 1'b1;
         EVK_ATX: pend[EV_ATX] = 1'b1;
         EVK_ARX: pend[EV_ARX] = 1'b1;
         default: ;
      endcase
      while (busy && guard < SERVE_LIMIT && n < RESULT_LIMIT) begin
         busy = serve_one(has_cmd, cmd);
         if (busy && has_cmd) begin
            cmds[n] = cmd;
            n++;
         end
         guard++;
      end
      for (int i = 0; i < n; i++) begin
         cmd      = cmds[i];
         cmd.last = (i == n - 1);
         expected_cmds.push_back(cmd);
      end
   endfunction

   task automatic report_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.dest_id       = DEST_ID_RESET;
         cfg.max_retx      = MAX_RETX_RESET;
         cfg.seq_modulus   = SEQ_MODULUS_RESET;
         cfg.timeout_ticks = TIMEOUT_TICKS_RESET;
         link_state        = LINK_IDLE;
         next_seq_num      = '0;
         out_seq           = '0;
         retries           = '0;
         tick_count        = '0;
         timer_on          = 1'b0;
         pend              = '0;
         pend_rx_seq       = '0;
         pend_rx_src       = '0;
         expected_cmds.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_DEST_ID:       cfg.dest_id       = csr_write_data[FIELD_W-1:0];
               CSR_MAX_RETX:      cfg.max_retx      = csr_write_data[FIELD_W-1:0];
               CSR_SEQ_MODULUS:   cfg.seq_modulus   = csr_write_data[FIELD_W-1:0];
               CSR_TIMEOUT_TICKS: cfg.timeout_ticks = csr_write_data[TICKS_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            events_seen++;
            predict_link_commands(req_mon.req_type, req_mon.rx_seq, req_mon.rx_src);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            cmds_seen++;
            if (expected_cmds.size() == 0) begin
               errors++;
               $display("%0t: unexpected link command, expected none, got action %0d seq %h",
                        $time, rsp_mon.action, rsp_mon.seq);
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_mon.action !== want.action)
                  report_field("action", 8'(want.action), 8'(rsp_mon.action));
               if (rsp_mon.seq !== want.seq)
                  report_field("seq", want.seq, rsp_mon.seq);
               if (rsp_mon.dest !== want.dest)
                  report_field("dest", want.dest, rsp_mon.dest);
               if (rsp_mon.state_now !== want.state_now)
                  report_field("state_now", 8'(want.state_now), 8'(rsp_mon.state_now));
               if (rsp_mon.last !== want.last)
                  report_field("last", 8'(want.last), 8'(rsp_mon.last));
            end
         end
      end
      fail_count   <= errors;
      expect_count <= expected_cmds.size();
      event_count  <= events_seen;
      cmd_count    <= cmds_seen;
   end

   initial begin
      errors      = 0;
      events_seen = 0;
      cmds_seen   = 0;
   end

endmodule

// ----- dv/stop_and_wait_arq_controller_unit_tb.sv -----
// Testbench top for the stop-and-wait ARQ controller: clock, reset, CSR setup,
// event stimulus under several throttle profiles, and the final verdict.
// Depends on sawarq_pkg, sawarq_if, the controller RTL and sawarq_link_checker.
`timescale 1ns / 1ps

module stop_and_wait_arq_controller_unit_tb;
   import sawarq_pkg::*;

   localparam int STALL_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 30;
   localparam int PHASE_ITEMS   = 14;
   localparam int SQUEEZE_ITEMS = 12;

   // req_type codes the block ignores
   localparam logic [REQ_TYPE_W-1:0] EVK_UNUSED_LO = 3'd6;
   localparam logic [REQ_TYPE_W-1:0] EVK_UNUSED_HI = 3'd7;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   int                     send_idle_pct;
   int                     rsp_stall_pct;
   logic                   hold_req;
   int                     quiet_cycles;
   int                     fail_count;
   int                     expect_count;
   int                     event_count;
   int                     cmd_count;

   sawarq_req_if req_chan ();
   sawarq_rsp_if rsp_chan ();

   stop_and_wait_arq_controller_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   sawarq_link_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .expect_count   (expect_count),
      .event_count    (event_count),
      .cmd_count      (cmd_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always_ff @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // Response side: random stalls, plus one long hold-off on request
   initial begin
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic logic [FIELD_W-1:0] rand_byte();
      rand_byte = FIELD_W'($urandom);
   endfunction

   task automatic send_event(input logic [REQ_TYPE_W-1:0] kind, input logic [FIELD_W-1:0] s,
                             input logic [FIELD_W-1:0] src);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.rx_seq   <= s;
      req_chan.rx_src   <= src;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
   endtask

   // Wait until every predicted command is back, then give the event queue time to drain
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expect_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   task automatic load_config(input logic [FIELD_W-1:0] dest, input logic [FIELD_W-1:0] retx,
                              input logic [FIELD_W-1:0] modulus, input logic [TICKS_W-1:0] ticks);
      write_reg(CSR_DEST_ID, {8'h00, dest});
      write_reg(CSR_MAX_RETX, {8'h00, retx});
      write_reg(CSR_SEQ_MODULUS, {8'h00, modulus});
      write_reg(CSR_TIMEOUT_TICKS, ticks);
      csr_write_en <= 1'b0;
   endtask

   // One random exchange: mostly well-formed outbound or inbound flows, some noise
   task automatic random_exchange(output int sent);
      int                    pick;
      int                    rounds;
      logic [REQ_TYPE_W-1:0] kind;
      sent = 0;
      pick = $urandom_range(9);
      if (pick < 5) begin
         send_event(EVK_SDU, rand_byte(), rand_byte());
         send_event(EVK_DTX, rand_byte(), rand_byte());
         sent   = 2;
         rounds = $urandom_range(3);
         repeat (rounds) begin
            // send one to four timer ticks, then a data-sent event for a possible resend
            repeat ($urandom_range(1, 4)) begin
               send_event(EVK_TICK, rand_byte(), rand_byte());
               sent++;
            end
            send_event(EVK_DTX, rand_byte(), rand_byte());
            sent++;
         end
         if ($urandom_range(3) != 0) begin
            send_event(EVK_ARX, rand_byte(), rand_byte());
            sent++;
         end
      end else if (pick < 7) begin
         send_event(EVK_DRX, rand_byte(), rand_byte());
         sent = 1;
         if ($urandom_range(1) != 0) begin
            send_event(EVK_TICK, rand_byte(), rand_byte());
            sent++;
         end
         send_event(EVK_ATX, rand_byte(), rand_byte());
         sent++;
      end else begin
         repeat ($urandom_range(1, 3)) begin
            kind = REQ_TYPE_W'($urandom_range(7));
            send_event(kind, rand_byte(), rand_byte());
            if (kind <= EVK_ARX) sent++;
         end
      end
   endtask

   task automatic run_random(input int target);
      int total;
      int sent;
      total = 0;
      while (total < target) begin
         random_exchange(sent);
         total += sent;
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.req_type <= EVK_TICK;
      req_chan.rx_seq   <= '0;
      req_chan.rx_src   <= '0;
      csr_write_en      <= 1'b0;
      csr_index         <= CSR_DEST_ID;
      csr_write_data    <= '0;
      send_idle_pct     <= 0;
      rsp_stall_pct     <= 0;
      hold_req          <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      drain();

      // Directed: rejections, ignored codes, retry/give-up, stale timeout, seq wrap
      load_config(8'hA5, 8'd1, 8'd3, 16'd2);
      send_event(EVK_ATX, 8'h00, 8'h00);
      send_event(EVK_ARX, 8'h77, 8'h88);
      send_event(EVK_DTX, 8'h00, 8'h00);
      send_event(EVK_UNUSED_LO, 8'hFF, 8'hFF);
      send_event(EVK_UNUSED_HI, 8'h00, 8'h00);
      send_event(EVK_TICK, 8'h00, 8'h00);
      send_event(EVK_SDU, 8'h00, 8'h00);
      send_event(EVK_SDU, 8'h00, 8'h00);
      send_event(EVK_DTX, 8'h00, 8'h00);
      send_event(EVK_DRX, 8'hFF, 8'hFF);
      // timer keeps running in tx; timeout becomes pending there
      send_event(EVK_TICK, 8'h00, 8'h00);
      send_event(EVK_TICK, 8'h00, 8'h00);
      send_event(EVK_ATX, 8'h00, 8'h00);
      send_event(EVK_DTX, 8'h00, 8'h00);
      send_event(EVK_TICK, 8'h00, 8'h00);
      send_event(EVK_TICK, 8'h00, 8'h00);
      send_event(EVK_DRX, 8'h00, 8'h00);
      send_event(EVK_ARX, 8'h00, 8'h00);
      // newer received PDU overwrites the pending one
      send_event(EVK_DRX, 8'h5A, 8'hC3);
      send_event(EVK_DRX, 8'hA5, 8'h3C);
      send_event(EVK_ATX, 8'h00, 8'h00);
      send_event(EVK_ATX, 8'h00, 8'h00);
      send_event(EVK_SDU, 8'h00, 8'h00);
      send_event(EVK_DTX, 8'h00, 8'h00);
      send_event(EVK_ARX, 8'h00, 8'h00);
      send_event(EVK_SDU, 8'h00, 8'h00);
      send_event(EVK_DTX, 8'h00, 8'h00);
      send_event(EVK_ARX, 8'h00, 8'h00);
      drain();

      load_config(rand_byte(), 8'd0, 8'd2, 16'd1);
      run_random(PHASE_ITEMS);
      drain();

      send_idle_pct <= 64;
      load_config(8'hFF, 8'hFF, 8'hFF, 16'd3);
      run_random(PHASE_ITEMS);
      drain();

      // zero modulus and zero timeout
      send_idle_pct <= 0;
      rsp_stall_pct <= 64;
      load_config(8'h00, 8'd2, 8'd0, 16'd0);
      run_random(PHASE_ITEMS);
      drain();

      send_idle_pct <= 36;
      rsp_stall_pct <= 36;
      load_config(rand_byte(), 8'd1, 8'd1, 16'd2);
      run_random(PHASE_ITEMS);
      drain();

      // long response hold-off so the input side backs up
      send_idle_pct <= 0;
      rsp_stall_pct <= 0;
      load_config(rand_byte(), 8'd3, 8'd5, 16'hFFFF);
      hold_req <= 1'b1;
      run_random(SQUEEZE_ITEMS);
      drain();

      $display("Summary: %0d event transactions over directed, throttled and hold-off phases",
               event_count);
      $display("Summary: %0d link commands compared field by field", cmd_count);
      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/sawarq_pkg.sv
hdl/sawarq_if.sv
hdl/sawarq_front.sv
hdl/sawarq_back.sv
hdl/stop_and_wait_arq_controller_unit.sv
dv/sawarq_link_checker.sv
dv/stop_and_wait_arq_controller_unit_tb.sv
